>>> design/b32d_pkg.sv
// ----------------------------------------------------------------------------
// b32d_pkg
// Shared types, constants and the symbol classifier of the base32 decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b32d_pkg;

  // Decoded value and capacity widths
  localparam int unsigned ValueW    = 5;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned CountW    = 16;
  localparam int unsigned PosW      = 3;

  // Capacity after reset
  localparam logic [CountW-1:0] CapacityReset = 16'hFFFF;

  // Queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // Alphabet boundaries (ASCII)
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharDigit2 = 8'h32;
  localparam logic [7:0] CharDigit7 = 8'h37;
  localparam logic [7:0] DigitBase  = 8'd26;

  // One classified character as it travels through the queue
  typedef struct packed {
    logic              first;
    logic              last;
    logic              is_sym;
    logic [ValueW-1:0] value;
  } sym_t;

  // Map an ASCII code to its 5-bit value; is_sym low outside the alphabet
  function automatic sym_t classify(input logic [7:0] c, input logic first,
                                    input logic last);
    sym_t       s;
    logic [7:0] diff;
    s.first  = first;
    s.last   = last;
    s.is_sym = 1'b0;
    s.value  = '0;
    diff     = '0;
    if (c >= CharUpperA && c <= CharUpperZ) begin
      diff     = c - CharUpperA;
      s.is_sym = 1'b1;
      s.value  = diff[ValueW-1:0];
    end else if (c >= CharDigit2 && c <= CharDigit7) begin
      diff     = c - CharDigit2 + DigitBase;
      s.is_sym = 1'b1;
      s.value  = diff[ValueW-1:0];
    end
    return s;
  endfunction

endpackage

`default_nettype wire

>>> design/b32d_front.sv
// ----------------------------------------------------------------------------
// b32d_front
// Input stage: takes character transactions, classifies them and registers
// the result for the queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32d_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire logic [7:0]    symbol_i,
  input  wire logic          first_i,
  input  wire logic          last_i,
  output logic               fr_valid_o,
  input  wire logic          fr_ready_i,
  output b32d_pkg::sym_t     fr_item_o
);

  logic           valid_q, valid_d;
  b32d_pkg::sym_t item_q;
  logic           accept;

  // Stage is free when empty or when the queue takes its content
  assign in_ready_o = !valid_q || fr_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (fr_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Classified payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= b32d_pkg::classify(symbol_i, first_i, last_i);
    end
  end

  assign fr_valid_o = valid_q;
  assign fr_item_o  = item_q;

endmodule

`default_nettype wire

>>> design/b32d_queue.sv
// ----------------------------------------------------------------------------
// b32d_queue
// Short FIFO between the front and back stages so each can stall alone.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32d_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          wr_valid_i,
  output logic               wr_ready_o,
  input  wire b32d_pkg::sym_t wr_item_i,
  output logic               rd_valid_o,
  input  wire logic          rd_ready_i,
  output b32d_pkg::sym_t     rd_item_o
);

  localparam logic [b32d_pkg::QueueCntW-1:0] Full =
    b32d_pkg::QueueCntW'(b32d_pkg::QueueDepth);
  localparam logic [b32d_pkg::QueuePtrW-1:0] LastIdx =
    b32d_pkg::QueuePtrW'(b32d_pkg::QueueDepth - 1);

  b32d_pkg::sym_t                  mem_q [b32d_pkg::QueueDepth];
  logic [b32d_pkg::QueuePtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [b32d_pkg::QueuePtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [b32d_pkg::QueueCntW-1:0]  cnt_q, cnt_d;
  logic                            push, pop;

  assign wr_ready_o = (cnt_q != Full);
  assign rd_valid_o = (cnt_q != '0);
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;
  assign rd_item_o  = mem_q[rd_ptr_q];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

`ifndef SYNTH
  // Fill count never passes the depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("queue fill count beyond depth");

  // Empty or full both mean the pointers coincide
  a_ptr_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || cnt_q == Full) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers out of step with fill count");
`endif

endmodule

`default_nettype wire

>>> design/b32d_back.sv
// ----------------------------------------------------------------------------
// b32d_back
// Decode stage: gathers 5-bit values into bytes, counts bytes against the
// capacity and holds each result in an output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module b32d_back (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [b32d_pkg::CountW-1:0]     capacity_i,
  input  wire logic                            item_valid_i,
  output logic                                 item_ready_o,
  input  wire b32d_pkg::sym_t                  item_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic                                 byte_valid_o,
  output logic [b32d_pkg::ByteW-1:0]           data_byte_o,
  output logic                                 message_done_o,
  output logic [b32d_pkg::CountW-1:0]          byte_count_o
);

  localparam int unsigned ShW = b32d_pkg::ValueW + b32d_pkg::ByteW;

  // Message state
  logic [b32d_pkg::PosW-1:0]   pos_q, pos_d;
  logic [b32d_pkg::ByteW-1:0]  part_q, part_d;
  logic [b32d_pkg::CountW-1:0] cnt_q, cnt_d;
  logic                        stop_q, stop_d;

  // Output register
  logic                        ovalid_q, ovalid_d;
  logic                        obyte_v_q, obyte_v_d;
  logic [b32d_pkg::ByteW-1:0]  obyte_q, obyte_d;
  logic                        odone_q, odone_d;
  logic [b32d_pkg::CountW-1:0] ocnt_q;

  logic                        take;
  logic [b32d_pkg::PosW-1:0]   pos_c, np;
  logic [b32d_pkg::ByteW-1:0]  part_c;
  logic [b32d_pkg::CountW-1:0] cnt_c;
  logic                        stop_c;
  logic [ShW-1:0]              sh;

  assign item_ready_o = !ovalid_q || out_ready_i;
  assign take         = item_valid_i && item_ready_o;

  // Start of message clears state ahead of this character
  always_comb begin
    pos_c  = item_i.first ? '0   : pos_q;
    part_c = item_i.first ? '0   : part_q;
    cnt_c  = item_i.first ? '0   : cnt_q;
    stop_c = item_i.first ? 1'b0 : stop_q;
  end

  // Value placed below the already gathered bits: upper part closes the
  // byte, lower part starts the next one
  assign np = pos_c + b32d_pkg::PosW'(b32d_pkg::ValueW);
  assign sh = {item_i.value, {b32d_pkg::ByteW{1'b0}}} >> np;

  always_comb begin
    pos_d     = pos_q;
    part_d    = part_q;
    cnt_d     = cnt_q;
    stop_d    = stop_q;
    obyte_v_d = 1'b0;
    obyte_d   = '0;
    odone_d   = item_i.last;
    if (take) begin
      pos_d  = pos_c;
      part_d = part_c;
      cnt_d  = cnt_c;
      stop_d = stop_c;
      if (item_i.is_sym && !stop_c) begin
        pos_d = np;
        if (pos_c <= 3'd3 && np != '0) begin
          part_d = part_c | sh[b32d_pkg::ByteW-1:0];
        end else begin
          obyte_v_d = 1'b1;
          obyte_d   = part_c | {3'b000, sh[ShW-1:b32d_pkg::ByteW]};
          part_d    = sh[b32d_pkg::ByteW-1:0];
          cnt_d     = cnt_c + 1'b1;
          if (cnt_d >= capacity_i) begin
            stop_d  = 1'b1;
            odone_d = 1'b1;
          end
        end
      end
    end
  end

  // Output register fills on take, empties when the result is taken
  always_comb begin
    ovalid_d = ovalid_q;
    if (take) begin
      ovalid_d = 1'b1;
    end else if (out_ready_i) begin
      ovalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= '0;
      part_q   <= '0;
      cnt_q    <= '0;
      stop_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      part_q   <= part_d;
      cnt_q    <= cnt_d;
      stop_q   <= stop_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      obyte_v_q <= obyte_v_d;
      obyte_q   <= obyte_d;
      odone_q   <= odone_d;
      ocnt_q    <= cnt_d;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign byte_valid_o   = obyte_v_q;
  assign data_byte_o    = obyte_q;
  assign message_done_o = odone_q;
  assign byte_count_o   = ocnt_q;

`ifndef SYNTH
  // A byte boundary always leaves an empty partial byte
  a_part_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == '0) |-> (part_q == '0))
    else $error("partial byte not clear at byte boundary");

  // A given byte is counted in the same result
  a_byte_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ovalid_q && obyte_v_q) |-> (ocnt_q == cnt_q))
    else $error("byte count does not match given byte");
`endif

endmodule

`default_nettype wire

>>> design/base32_decoder_top.sv
// Path: an input transaction reaches the result through the input stage,
//   the two-entry queue and the decode output register.
// Throughput: one character per cycle while out_ready_i is high; the byte
//   gathering and capacity compare in the decode stage are combinational.
// Reset: asynchronous, active low; clears message state, queue and handshake
//   state and sets the capacity to 65535.
// ----------------------------------------------------------------------------
// base32_decoder_top
// Streaming RFC 4648 base32 decoder, one character per transaction, one
// result per character, with a per-message byte capacity.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module base32_decoder_top (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [b32d_pkg::CountW-1:0] cfg_wdata_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [7:0]                  symbol_i,
  input  wire logic                        first_i,
  input  wire logic                        last_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic                             byte_valid_o,
  output logic [b32d_pkg::ByteW-1:0]       data_byte_o,
  output logic                             message_done_o,
  output logic [b32d_pkg::CountW-1:0]      byte_count_o
);

  logic [b32d_pkg::CountW-1:0] capacity_q;
  logic                        fr_valid, fr_ready;
  b32d_pkg::sym_t              fr_item;
  logic                        q_valid, q_ready;
  b32d_pkg::sym_t              q_item;

  // Capacity register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= b32d_pkg::CapacityReset;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  b32d_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .symbol_i   (symbol_i),
    .first_i    (first_i),
    .last_i     (last_i),
    .fr_valid_o (fr_valid),
    .fr_ready_i (fr_ready),
    .fr_item_o  (fr_item)
  );

  b32d_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (fr_valid),
    .wr_ready_o (fr_ready),
    .wr_item_i  (fr_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  b32d_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .capacity_i     (capacity_q),
    .item_valid_i   (q_valid),
    .item_ready_o   (q_ready),
    .item_i         (q_item),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .byte_valid_o   (byte_valid_o),
    .data_byte_o    (data_byte_o),
    .message_done_o (message_done_o),
    .byte_count_o   (byte_count_o)
  );

endmodule

`default_nettype wire
